// ----- hdl/dht_pkg.sv -----
// Shared constants, codes, state type and the remainder step of the double hashing table.
// No dependencies; imported by double_hashing_table, dht_checker and the testbench top.
`default_nettype none

package dht_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int KEY_WIDTH = 32;

	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int SIZE_W    = IDX_W + 1;
	localparam int CFG_W     = 5;
	localparam int HASH_PRIME = 7;
	// remainder width that covers both the slot modulus and the prime
	localparam int RES_W     = (IDX_W > 3) ? IDX_W : 3;
	localparam int MOD_W     = RES_W + 1;
	localparam int MAG_STEPS = KEY_WIDTH / 2;
	localparam int CNT_W     = $clog2((MAG_STEPS > MAX_SLOTS) ? MAG_STEPS : MAX_SLOTS);

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_TABLE_SIZE = 1'b0;
	localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(11);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] TAG_EMPTY = 2'd0;
	localparam logic [1:0] TAG_USED  = 2'd1;
	localparam logic [1:0] TAG_GONE  = 2'd2;

	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_DELETED   = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;
	localparam logic [2:0] ST_FAILED    = 3'd5;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HASH,
		S_STEP,
		S_PROBE
	} state_t;

	// One radix-4 remainder step: (r*4 + b) mod m, valid while r < m.
	function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0] r,
			input logic [1:0] b, input logic [MOD_W-1:0] m);
		logic [RES_W+1:0] v;
		logic [RES_W+1:0] m1;
		logic [RES_W+1:0] m2;
		v  = {r, b};
		m1 = (RES_W + 2)'(m);
		m2 = {m, 1'b0};
		if (v >= m2) begin
			v = v - m2;
		end
		if (v >= m1) begin
			v = v - m1;
		end
		return v[RES_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- hdl/double_hashing_table.sv -----
// Open-addressing hash table with double hashing, slot tags in flops, keys in a slot array.
// Depends on dht_pkg (constants, codes, state type, remainder step).
//
// Channel   Direction  Handshake                    Payload
// request   in         start & !busy                operation, key
// result    out        done (one-cycle strobe)      status
// config    in         psel & penable & pwrite      paddr, pwdata (table_size), prdata
//
// A request answered at once (full table, unused code) never raises busy; done pulses in
// the cycle after its transfer. Any other holds busy for the remainder pass, the step
// reduction and 1 up to the effective size (at most MAX_SLOTS) probes, then done pulses.
// The remainder pass runs over the key magnitude in radix-4 digits (mod size and mod 7
// side by side), the step reduction takes the probe step mod size with the same unit,
// and each probe reads one slot. Reset clears all tags to empty at once; no sweep is
// needed. busy is low in the cycle done is high. The receiver cannot stall results.
`default_nettype none

module double_hashing_table (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [1:0]                   operation,
	input  wire logic signed [dht_pkg::KEY_WIDTH-1:0] key,
	output logic                              done,
	output logic [2:0]                        status,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [dht_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [dht_pkg::DATA_W-1:0]   pwdata,
	output logic [dht_pkg::DATA_W-1:0]        prdata,
	output logic                              pready
);
	import dht_pkg::*;

	state_t state_q, state_nxt;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [CFG_W-1:0]     size_q;
	logic [SIZE_W-1:0]    live_q;
	logic [1:0]           tags_q [MAX_SLOTS];
	logic [KEY_WIDTH-1:0] keys_q [MAX_SLOTS];

	logic [1:0]           op_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] mag_q;
	logic [RES_W-1:0]     rs_q;
	logic [RES_W-1:0]     r7_q;
	logic [IDX_W-1:0]     idx_q;
	logic [2:0]           status_q;

	logic [SIZE_W-1:0]    eff_s;
	logic [KEY_WIDTH-1:0] key_u;
	logic [KEY_WIDTH-1:0] key_mag;
	logic                 accept;
	logic                 quick;
	logic [2:0]           quick_status;
	logic                 cfg_wr;

	logic [RES_W-1:0]     u_r;
	logic [1:0]           u_b;
	logic [RES_W-1:0]     u_out;
	logic [RES_W-1:0]     r7_nxt;
	logic [2:0]           step;
	logic                 hash_last;

	logic [1:0]           tag_cur;
	logic                 key_hit;
	logic                 probe_last;
	logic                 finish;
	logic [2:0]           fin_status;
	logic                 set_used;
	logic                 set_gone;
	logic [SIZE_W-1:0]    idx_sum;
	logic [IDX_W-1:0]     idx_nxt;

	// ---- configuration port ----
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_SIZE);
	assign prdata = (paddr[2] == REG_TABLE_SIZE) ? DATA_W'(size_q) : '0;

	always_comb begin
		if (size_q == '0) begin
			eff_s = SIZE_W'(1);
		end else if (size_q > CFG_W'(MAX_SLOTS)) begin
			eff_s = SIZE_W'(MAX_SLOTS);
		end else begin
			eff_s = SIZE_W'(size_q);
		end
	end

	// ---- request decode ----
	assign key_u   = key;
	assign key_mag = key_u[KEY_WIDTH-1] ? (~key_u + KEY_WIDTH'(1)) : key_u;
	assign accept  = start && !busy;

	always_comb begin
		quick        = 1'b0;
		quick_status = ST_FULL;
		if (operation != OP_INSERT && operation != OP_SEARCH && operation != OP_DELETE) begin
			quick        = 1'b1;
			quick_status = ST_NOT_FOUND;
		end else if (operation == OP_INSERT && live_q >= eff_s) begin
			quick = 1'b1;
		end
	end

	// ---- shared remainder unit ----
	assign step      = 3'(HASH_PRIME) - r7_q[2:0];
	assign hash_last = (cnt_q == CNT_W'(MAG_STEPS - 1));

	always_comb begin
		if (state_q == S_STEP) begin
			u_r = cnt_q[0] ? rs_q : '0;
			u_b = cnt_q[0] ? step[1:0] : {1'b0, step[2]};
		end else begin
			u_r = rs_q;
			u_b = mag_q[KEY_WIDTH-1 -: 2];
		end
	end

	assign u_out  = mod_step(u_r, u_b, MOD_W'(eff_s));
	assign r7_nxt = mod_step(r7_q, mag_q[KEY_WIDTH-1 -: 2], MOD_W'(HASH_PRIME));

	// ---- probe path ----
	assign tag_cur    = tags_q[idx_q];
	assign key_hit    = (keys_q[idx_q] == key_q);
	assign probe_last = (cnt_q == CNT_W'(eff_s - SIZE_W'(1)));
	assign idx_sum    = SIZE_W'(idx_q) + SIZE_W'(rs_q[IDX_W-1:0]);
	assign idx_nxt    = (idx_sum >= eff_s) ? IDX_W'(idx_sum - eff_s) : IDX_W'(idx_sum);

	// ---- next state ----
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !quick) begin
					state_nxt = S_HASH;
				end
			end
			S_HASH: begin
				if (hash_last) begin
					state_nxt = S_STEP;
				end
			end
			S_STEP: begin
				if (cnt_q[0]) begin
					state_nxt = S_PROBE;
				end
			end
			S_PROBE: begin
				if (finish) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// ---- outputs of the sequencer ----
	always_comb begin
		busy       = (state_q != S_IDLE);
		finish     = 1'b0;
		fin_status = ST_NOT_FOUND;
		set_used   = 1'b0;
		set_gone   = 1'b0;
		unique case (state_q)
			S_PROBE: begin
				if (op_q == OP_INSERT) begin
					if (tag_cur == TAG_EMPTY) begin
						finish     = 1'b1;
						set_used   = 1'b1;
						fin_status = ST_INSERTED;
					end else if (probe_last) begin
						finish     = 1'b1;
						fin_status = ST_FAILED;
					end
				end else if (tag_cur == TAG_USED && key_hit) begin
					finish = 1'b1;
					if (op_q == OP_DELETE) begin
						set_gone   = 1'b1;
						fin_status = ST_DELETED;
					end else begin
						fin_status = ST_FOUND;
					end
				end else if (tag_cur == TAG_EMPTY || probe_last) begin
					finish     = 1'b1;
					fin_status = ST_NOT_FOUND;
				end
			end
			default: begin
			end
		endcase
	end

	assign done   = done_q;
	assign status = status_q;

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			size_q  <= SIZE_RESET;
			live_q  <= '0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				tags_q[i] <= TAG_EMPTY;
			end
		end else begin
			state_q <= state_nxt;
			cnt_q   <= (state_nxt != state_q) ? '0 : cnt_q + CNT_W'(1);
			done_q  <= (accept && quick) || finish;
			if (cfg_wr) begin
				size_q <= pwdata[CFG_W-1:0];
			end
			if (set_used) begin
				tags_q[idx_q] <= TAG_USED;
				live_q        <= live_q + SIZE_W'(1);
			end
			if (set_gone) begin
				tags_q[idx_q] <= TAG_GONE;
				if (live_q != '0) begin
					live_q <= live_q - SIZE_W'(1);
				end
			end
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= operation;
			key_q    <= key_u;
			mag_q    <= key_mag;
			rs_q     <= '0;
			r7_q     <= '0;
			status_q <= quick_status;
		end
		if (state_q == S_HASH) begin
			mag_q <= {mag_q[KEY_WIDTH-3:0], 2'b00};
			rs_q  <= u_out;
			r7_q  <= r7_nxt;
			if (hash_last) begin
				idx_q <= u_out[IDX_W-1:0];
			end
		end
		if (state_q == S_STEP) begin
			rs_q <= u_out;
		end
		if (state_q == S_PROBE) begin
			idx_q <= idx_nxt;
			if (finish) begin
				status_q <= fin_status;
			end
		end
		if (set_used) begin
			keys_q[idx_q] <= key_q;
		end
	end

	// ---- assertions ----
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while a request is still in work");

	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= SIZE_W'(MAX_SLOTS))
		else $error("live count above slot count");

	a_probe_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PROBE) |-> (SIZE_W'(idx_q) < eff_s && SIZE_W'(rs_q) < eff_s))
		else $error("probe index or step outside table size");

	a_live_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(live_q) |-> done_q)
		else $error("live count changed without a result transfer");

	a_hash_to_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HASH && hash_last) |=> (state_q == S_STEP && cnt_q == '0))
		else $error("remainder pass did not hand over to step reduction");

endmodule

`default_nettype wire

// ----- test/dht_checker.sv -----
// Scoreboard for the double hashing table: models the slot tags, keys, live count and size.
// Watches the request, result and APB channels of the block; depends on dht_pkg.
`timescale 1ns / 1ps

module dht_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           busy,
	input  logic [1:0]                     operation,
	input  logic [dht_pkg::KEY_WIDTH-1:0]  key,
	input  logic                           done,
	input  logic [2:0]                     status,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dht_pkg::ADDR_W-1:0]     paddr,
	input  logic [dht_pkg::DATA_W-1:0]     pwdata,
	input  logic                           pready,
	output int                             fail_count,
	output int                             open_count
);
	import dht_pkg::*;

	localparam logic [ADDR_W-1:0] ADDR_TABLE_SIZE = ADDR_W'(4 * int'(REG_TABLE_SIZE));

	logic [KEY_WIDTH-1:0] slot_key [MAX_SLOTS];
	logic [1:0]           slot_tag [MAX_SLOTS];
	int unsigned          live_slots;
	logic [CFG_W-1:0]     size_reg;
	logic [2:0]           status_due_q [$];

	function automatic int unsigned active_slots();
		int unsigned s;
		s = size_reg;
		if (s == 0) begin
			s = 1;
		end
		if (s > MAX_SLOTS) begin
			s = MAX_SLOTS;
		end
		return s;
	endfunction

	function automatic int unsigned probe_index(longint unsigned mag, int unsigned i,
			int unsigned s);
		longint unsigned stride;
		stride = HASH_PRIME - (mag % HASH_PRIME);
		return int'((mag % s + (stride * i) % s) % s);
	endfunction

	// slot of a live copy of the key, or -1; tombstones are skipped, empty ends the walk
	function automatic int find_live(logic [KEY_WIDTH-1:0] k, longint unsigned mag,
			int unsigned s);
		int unsigned idx;
		for (int unsigned i = 0; i < s; i++) begin
			idx = probe_index(mag, i, s);
			if (slot_tag[idx] == TAG_USED && slot_key[idx] == k) begin
				return int'(idx);
			end
			if (slot_tag[idx] == TAG_EMPTY) begin
				return -1;
			end
		end
		return -1;
	endfunction

	// apply one request to the table copy and return the status it must answer
	function automatic logic [2:0] table_op(logic [1:0] op, logic [KEY_WIDTH-1:0] k);
		logic [KEY_WIDTH-1:0] neg;
		longint unsigned      mag;
		int unsigned          s;
		int unsigned          idx;
		int                   hit;
		logic [2:0]           st;
		neg = ~k + 1'b1;
		mag = k[KEY_WIDTH-1] ? neg : k;
		s   = active_slots();
		st  = ST_NOT_FOUND;
		case (op)
			OP_INSERT: begin
				if (live_slots >= s) begin
					st = ST_FULL;
				end else begin
					st = ST_FAILED;
					for (int unsigned i = 0; i < s; i++) begin
						idx = probe_index(mag, i, s);
						if (slot_tag[idx] == TAG_EMPTY) begin
							slot_tag[idx] = TAG_USED;
							slot_key[idx] = k;
							live_slots++;
							st = ST_INSERTED;
							break;
						end
					end
				end
			end
			OP_SEARCH: begin
				hit = find_live(k, mag, s);
				st = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
			end
			OP_DELETE: begin
				hit = find_live(k, mag, s);
				if (hit >= 0) begin
					slot_tag[hit] = TAG_GONE;
					if (live_slots > 0) begin
						live_slots--;
					end
					st = ST_DELETED;
				end
			end
			default: begin
				st = ST_NOT_FOUND;
			end
		endcase
		return st;
	endfunction

	task automatic flag_error(string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t ns: %s", $time, msg);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [2:0] want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_SLOTS; i++) begin
				slot_tag[i] = TAG_EMPTY;
				slot_key[i] = '0;
			end
			live_slots = 0;
			size_reg   = SIZE_RESET;
			status_due_q.delete();
			fail_count = 0;
			open_count <= 0;
		end else begin
			// the result of the previous request retires before a new one is taken
			if (done) begin
				if (status_due_q.size() == 0) begin
					flag_error($sformatf("status %0d with no request outstanding", status));
				end else begin
					want = status_due_q.pop_front();
					if (status !== want) begin
						flag_error($sformatf("status mismatch: expected %0d, got %0d",
							want, status));
					end
				end
			end
			if (psel && penable && pwrite && pready && paddr == ADDR_TABLE_SIZE) begin
				size_reg = pwdata[CFG_W-1:0];
			end
			if (start && !busy) begin
				status_due_q.push_back(table_op(operation, key));
			end
			open_count <= status_due_q.size();
		end
	end

endmodule

// ----- test/tb_double_hashing_table.sv -----
// Top of the double hashing table testbench: clock, reset, request and APB stimulus, verdict.
// Depends on dht_pkg, double_hashing_table and dht_checker.
`timescale 1ns / 1ps

module tb_double_hashing_table;
	import dht_pkg::*;

	localparam logic [1:0]        OP_SPARE  = 2'd3;
	localparam logic [KEY_WIDTH-1:0] KEY_MAX = 32'h7fff_ffff;
	localparam logic [KEY_WIDTH-1:0] KEY_MIN = 32'h8000_0000;
	localparam logic [ADDR_W-1:0] ADDR_TABLE_SIZE = ADDR_W'(4 * int'(REG_TABLE_SIZE));
	localparam int                PHASES    = 12;
	localparam int                PHASE_LEN = 80;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic [1:0]           operation = OP_INSERT;
	logic [KEY_WIDTH-1:0] key       = '0;
	logic                 psel      = 1'b0;
	logic                 penable   = 1'b0;
	logic                 pwrite    = 1'b0;
	logic [ADDR_W-1:0]    paddr     = '0;
	logic [DATA_W-1:0]    pwdata    = '0;
	logic                 busy;
	logic                 done;
	logic [2:0]           status;
	logic [DATA_W-1:0]    prdata;
	logic                 pready;
	int                   fail_count;
	int                   open_count;

	logic [CFG_W-1:0]     size_plan [PHASES] = '{3, 1, 7, 16, 5, 0, 20, 2, 9, 13, 11, 31};
	int                   gap_plan  [3]      = '{0, 63, 19};
	logic [KEY_WIDTH-1:0] key_pool  [16];
	int                   op_count  [4]      = '{0, 0, 0, 0};
	int                   gap_pct            = 0;
	int                   size_writes        = 0;

	double_hashing_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.key       (key),
		.done      (done),
		.status    (status),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	dht_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.key        (key),
		.done       (done),
		.status     (status),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.open_count (open_count)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// hold start high until the transfer happens; a gap lowers it first
	task automatic issue_request(logic [1:0] op, logic [KEY_WIDTH-1:0] k);
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		key       <= k;
		op_count[op]++;
		do @(posedge clk); while (busy);
	endtask

	task automatic await_idle();
		start <= 1'b0;
		@(posedge clk);
		while (open_count != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_size(logic [CFG_W-1:0] sz);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_TABLE_SIZE;
		pwdata  <= {(DATA_W - CFG_W)'($urandom()), sz};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		size_writes++;
	endtask

	function automatic logic [1:0] pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 40) begin
			return OP_INSERT;
		end
		if (r < 75) begin
			return OP_SEARCH;
		end
		if (r < 95) begin
			return OP_DELETE;
		end
		return OP_SPARE;
	endfunction

	// mostly pool keys so searches and deletes hit, negated ones to share a magnitude
	function automatic logic [KEY_WIDTH-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 65) begin
			return key_pool[$urandom_range(15)];
		end
		if (r < 75) begin
			return -key_pool[$urandom_range(15)];
		end
		return $urandom();
	endfunction

	initial begin
		key_pool[0] = '0;
		key_pool[1] = KEY_MAX;
		key_pool[2] = KEY_MIN;
		key_pool[3] = -32'sd1;
		key_pool[4] = -32'sd2;
		for (int i = 5; i < 16; i++) begin
			key_pool[i] = (i % 2 == 0) ? $urandom() : $urandom_range(1, 64);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// two slots: fill, delete, then a key whose step never leaves the tombstone
		write_size(2);
		issue_request(OP_INSERT, 32'd4);
		issue_request(OP_INSERT, 32'd6);
		issue_request(OP_INSERT, 32'd9);
		issue_request(OP_DELETE, 32'd4);
		issue_request(OP_INSERT, 32'd8);
		issue_request(OP_SEARCH, 32'd6);
		await_idle();
		// size zero acts as one slot; the live key above it is no longer probed
		write_size(0);
		issue_request(OP_INSERT, 32'd3);
		issue_request(OP_SEARCH, 32'd6);
		await_idle();
		write_size(31);
		issue_request(OP_SEARCH, KEY_MAX);
		issue_request(OP_INSERT, '0);
		issue_request(OP_INSERT, KEY_MAX);
		issue_request(OP_INSERT, KEY_MIN);
		issue_request(OP_INSERT, -32'sd1);
		issue_request(OP_INSERT, -32'sd2);
		issue_request(OP_INSERT, 32'd1);
		issue_request(OP_INSERT, -32'sd1);
		issue_request(OP_DELETE, -32'sd1);
		issue_request(OP_SEARCH, -32'sd1);
		issue_request(OP_DELETE, -32'sd1);
		issue_request(OP_SEARCH, -32'sd1);
		issue_request(OP_DELETE, 32'd5);
		issue_request(OP_SPARE, -32'sd2);
		issue_request(OP_SEARCH, KEY_MIN);
		issue_request(OP_DELETE, '0);

		for (int p = 0; p < PHASES; p++) begin
			await_idle();
			write_size(size_plan[p]);
			gap_pct = gap_plan[p % 3];
			repeat (PHASE_LEN) begin
				issue_request(pick_op(), pick_key());
			end
		end

		gap_pct = 0;
		await_idle();
		repeat (40) @(posedge clk);

		$display("covered %0d inserts, %0d searches, %0d deletes, %0d unused codes",
			op_count[OP_INSERT], op_count[OP_SEARCH], op_count[OP_DELETE],
			op_count[OP_SPARE]);
		$display("over %0d table size writes from 0 to 31, request gaps of 0, 19, 63 pct",
			size_writes);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
